// ----- rtl/pcxrle_pkg.sv -----
package pcxrle_pkg;

   // Width of the column and row counters and of the size registers.
   localparam int COORD_BITS = 16;

   // Byte code that marks a run: both top bits set.
   localparam logic [7:0] RUN_MARK = 8'hC0;

   // Size registers after reset, cut to the counter width.
   localparam logic [COORD_BITS-1:0] WIDTH_RESET = COORD_BITS'(320);
   localparam logic [COORD_BITS-1:0] COUNT_RESET = COORD_BITS'(200);

   // Register byte addresses on the configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_ROW_WIDTH = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_ROW_COUNT = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       last_of_item;
      logic       row_end;
      logic       image_end;
   } rsp_type;

   // Commands from the sequencer to the position tracker.
   typedef struct packed {
      logic clear;
      logic step;
   } pos_ctrl_type;

   // Status from the position tracker, valid in the same cycle.
   typedef struct packed {
      logic row_end;
      logic image_end;
      logic image_done;
   } pos_stat_type;

endpackage

// ----- rtl/pcx_rle_scanline_decoder_top.sv -----
// PCX 8-bit run-length decoder. One compressed byte is taken per request and
// decoded pixels leave one per cycle on the result channel while it is not
// stalled. A literal byte gives one pixel and a run marker none; a run value
// byte holds the request channel while its pixels go out (1 to 63, fewer when
// the run is cut at the row end), as the single position tracker counts one
// pixel per step. A zero-length run and bytes after the last row give no
// pixel. A stalled result register holds off new requests. row_width sits at
// byte address 0 and row_count at 4; write them only while the block is idle.
module pcx_rle_scanline_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pcxrle_pkg::req_type                  req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pcxrle_pkg::rsp_type                  rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcxrle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import pcxrle_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic                  await_ff, await_in;
   logic [5:0]            run_len_ff, run_len_in;
   logic [5:0]            left_ff, left_in;
   logic [7:0]            value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [COORD_BITS-1:0] width_ff, width_in;
   logic [COORD_BITS-1:0] count_ff, count_in;

   logic                  out_free;
   logic                  accept;
   logic                  await_eff;
   logic                  csr_write;
   pos_ctrl_type          pos_ctrl;
   pos_stat_type          pos_stat;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in = width_ff;
      count_in = count_ff;
      if (csr_write) begin
         if (csr_paddr == ADDR_ROW_WIDTH) begin
            width_in = csr_pwdata[COORD_BITS-1:0];
         end
         if (csr_paddr == ADDR_ROW_COUNT) begin
            count_in = csr_pwdata[COORD_BITS-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_ROW_WIDTH) begin
         csr_prdata = 32'(width_ff);
      end else if (csr_paddr == ADDR_ROW_COUNT) begin
         csr_prdata = 32'(count_ff);
      end
   end

   // Handshake: the result register frees up when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign await_eff = req_data.frame_start ? 1'b0 : await_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: decode a byte, or play out a run one pixel per free cycle.
   always_comb begin
      state_in     = state_ff;
      await_in     = await_ff;
      run_len_in   = run_len_ff;
      left_in      = left_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pos_ctrl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_ctrl.clear = req_data.frame_start;
               if (req_data.frame_start) begin
                  await_in   = 1'b0;
                  run_len_in = '0;
               end
               if (pos_stat.image_done) begin
                  // Bytes past the last row are dropped.
               end else if (await_eff) begin
                  await_in   = 1'b0;
                  run_len_in = '0;
                  value_in   = req_data.data_byte;
                  left_in    = run_len_ff;
                  if (run_len_ff != '0) begin
                     state_in = ST_RUN;
                  end
               end else if ((req_data.data_byte & RUN_MARK) != RUN_MARK) begin
                  // Literal pixel.
                  pos_ctrl.step            = 1'b1;
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.pixel        = req_data.data_byte;
                  rsp_data_in.last_of_item = 1'b1;
                  rsp_data_in.row_end      = pos_stat.row_end;
                  rsp_data_in.image_end    = pos_stat.image_end;
               end else begin
                  // Run marker: hold the count for the next byte.
                  await_in   = 1'b1;
                  run_len_in = req_data.data_byte[5:0];
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               pos_ctrl.step            = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.pixel        = value_ff;
               rsp_data_in.last_of_item = (left_ff == 6'd1) || pos_stat.row_end;
               rsp_data_in.row_end      = pos_stat.row_end;
               rsp_data_in.image_end    = pos_stat.image_end;
               left_in                  = left_ff - 6'd1;
               if ((left_ff == 6'd1) || pos_stat.row_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pcxrle_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .row_width (width_ff),
      .row_count (count_ff),
      .ctrl      (pos_ctrl),
      .stat      (pos_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         await_ff     <= 1'b0;
         run_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         await_ff     <= await_in;
         run_len_ff   <= run_len_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/pcxrle_pos.sv -----
module pcxrle_pos (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pcxrle_pkg::COORD_BITS-1:0]  row_width,
   input  logic [pcxrle_pkg::COORD_BITS-1:0]  row_count,
   input  pcxrle_pkg::pos_ctrl_type           ctrl,
   output pcxrle_pkg::pos_stat_type           stat
);
   import pcxrle_pkg::*;

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  done_ff, done_in;

   logic [COORD_BITS-1:0] col_eff, row_eff;
   logic                  done_eff;
   logic [COORD_BITS:0]   col_next, row_next;
   logic                  rend, iend;

   // A frame start clears the position before the byte is decoded.
   assign col_eff  = ctrl.clear ? '0 : column_ff;
   assign row_eff  = ctrl.clear ? '0 : row_ff;
   assign done_eff = ctrl.clear ? 1'b0 : done_ff;

   // Shared compare unit: does the next pixel close the row, and the image?
   assign col_next = {1'b0, col_eff} + (COORD_BITS+1)'(1);
   assign row_next = {1'b0, row_eff} + (COORD_BITS+1)'(1);
   assign rend     = col_next >= {1'b0, row_width};
   assign iend     = rend && (row_next >= {1'b0, row_count});

   assign stat.row_end    = rend;
   assign stat.image_end  = iend;
   assign stat.image_done = done_eff;

   // Advance the position by one pixel on each step.
   always_comb begin
      column_in = col_eff;
      row_in    = row_eff;
      done_in   = done_eff;
      if (ctrl.step) begin
         if (rend) begin
            column_in = '0;
            if (iend) begin
               row_in  = '0;
               done_in = 1'b1;
            end else begin
               row_in = row_next[COORD_BITS-1:0];
            end
         end else begin
            column_in = col_next[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
      end
   end

endmodule
